[hdl/ith_pkg.sv]
// Shared types and constants for the IPv4 transport header parser.
// No dependencies; used by ith_capture, ith_check and the top level.
package ith_pkg;

	// Link header framing selected by configuration
	typedef enum logic [1:0] {
		LINK_ETH  = 2'd0,
		LINK_NULL = 2'd1,
		LINK_SLL  = 2'd2,
		LINK_NONE = 2'd3
	} link_t;

	// Protocol class reported with each result
	typedef enum logic [1:0] {
		KIND_TCP   = 2'd0,
		KIND_UDP   = 2'd1,
		KIND_ICMP  = 2'd2,
		KIND_OTHER = 2'd3
	} kind_t;

	localparam logic [4:0] ETH_HDR_BYTES  = 5'd14;
	localparam logic [4:0] NULL_HDR_BYTES = 5'd4;
	localparam logic [4:0] SLL_HDR_BYTES  = 5'd16;
	localparam logic [5:0] IP_MIN_BYTES   = 6'd20;
	localparam logic [5:0] TCP_MIN_BYTES  = 6'd20;
	localparam logic [5:0] UDP_HDR_BYTES  = 6'd8;
	localparam logic [3:0] IP_VERSION4    = 4'd4;
	localparam logic [3:0] IHL_MIN        = 4'd5;
	localparam logic [7:0] PROTO_ICMP     = 8'd1;
	localparam logic [7:0] PROTO_TCP      = 8'd6;
	localparam logic [7:0] PROTO_UDP      = 8'd17;
	localparam logic [15:0] PAY_MAX       = 16'hFFFF;

	// Header fields captured while a frame streams in
	typedef struct packed {
		logic [3:0]  version;
		logic [3:0]  words;
		logic [15:0] total;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [3:0]  toff;
		logic [7:0]  flags;
	} hdr_t;

	// One parse result
	typedef struct packed {
		logic        ok;
		kind_t       kind;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  flags;
		logic [15:0] pay;
	} res_t;

	// Link header length in bytes; zero for an unsupported link
	function automatic logic [4:0] link_len(input link_t link);
		case (link)
			LINK_ETH:  link_len = ETH_HDR_BYTES;
			LINK_NULL: link_len = NULL_HDR_BYTES;
			LINK_SLL:  link_len = SLL_HDR_BYTES;
			default:   link_len = 5'd0;
		endcase
	endfunction

endpackage

[hdl/ith_capture.sv]
// Byte offset counter and header field capture for one frame.
// Depends on ith_pkg; the state clears after each last byte.
module ith_capture import ith_pkg::*; #(
	parameter int COUNT_WIDTH = 17
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  link_t                  link_type,
	input  logic                   take,
	input  logic [7:0]             byte_value,
	input  logic                   last_byte,
	output hdr_t                   hdr_next,
	output logic [COUNT_WIDTH-1:0] len_next
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	hdr_t                   hdr_q;
	logic [COUNT_WIDTH-1:0] offset_q;

	logic [4:0]             lh;
	logic                   hit;
	logic [COUNT_WIDTH-1:0] p;
	logic [COUNT_WIDTH-1:0] hl;
	logic [COUNT_WIDTH-1:0] t;

	// Place the byte into the IPv4 or transport field at its position
	always_comb begin
		hdr_next = hdr_q;
		lh  = link_len(link_type);
		hit = (link_type != LINK_NONE) && (offset_q >= COUNT_WIDTH'(lh));
		p   = offset_q - COUNT_WIDTH'(lh);
		if (hit) begin
			if (p == COUNT_WIDTH'(0)) begin
				hdr_next.version = byte_value[7:4];
				hdr_next.words   = byte_value[3:0];
			end else if (p == COUNT_WIDTH'(2) || p == COUNT_WIDTH'(3)) begin
				hdr_next.total = {hdr_q.total[7:0], byte_value};
			end else if (p == COUNT_WIDTH'(9)) begin
				hdr_next.proto = byte_value;
			end else if (p >= COUNT_WIDTH'(12) && p < COUNT_WIDTH'(16)) begin
				hdr_next.src = {hdr_q.src[23:0], byte_value};
			end else if (p >= COUNT_WIDTH'(16) && p < COUNT_WIDTH'(20)) begin
				hdr_next.dst = {hdr_q.dst[23:0], byte_value};
			end
		end
		hl = COUNT_WIDTH'({hdr_next.words, 2'b00});
		t  = p - hl;
		if (hit && hdr_next.words >= IHL_MIN && p >= hl) begin
			if (t == COUNT_WIDTH'(0) || t == COUNT_WIDTH'(1)) begin
				hdr_next.sport = {hdr_q.sport[7:0], byte_value};
			end else if (t == COUNT_WIDTH'(2) || t == COUNT_WIDTH'(3)) begin
				hdr_next.dport = {hdr_q.dport[7:0], byte_value};
			end else if (t == COUNT_WIDTH'(12)) begin
				hdr_next.toff = byte_value[7:4];
			end else if (t == COUNT_WIDTH'(13)) begin
				hdr_next.flags = byte_value;
			end
		end
		len_next = (offset_q == COUNT_MAX) ? offset_q : offset_q + COUNT_WIDTH'(1);
	end

	// Advance on each request, clear after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= '0;
			offset_q <= '0;
		end else if (take) begin
			if (last_byte) begin
				hdr_q    <= '0;
				offset_q <= '0;
			end else begin
				hdr_q    <= hdr_next;
				offset_q <= len_next;
			end
		end
	end

endmodule

[hdl/ith_check.sv]
// Frame checks and payload length for a completed frame.
// Depends on ith_pkg; purely combinational.
module ith_check import ith_pkg::*; #(
	parameter int COUNT_WIDTH = 17
) (
	input  link_t                  link_type,
	input  hdr_t                   hdr,
	input  logic [COUNT_WIDTH-1:0] len,
	output res_t                   res
);

	localparam logic [COUNT_WIDTH-1:0] PAY_MAX_W = COUNT_WIDTH'(PAY_MAX);

	logic [COUNT_WIDTH-1:0] lh;
	logic [5:0]             hl;
	logic [5:0]             th;
	logic [COUNT_WIDTH-1:0] hdr_end;
	logic [COUNT_WIDTH-1:0] avail;
	logic [COUNT_WIDTH-1:0] tl;
	logic [COUNT_WIDTH-1:0] pay;
	logic                   fail;

	always_comb begin
		res     = '0;
		lh      = COUNT_WIDTH'(link_len(link_type));
		hl      = {hdr.words, 2'b00};
		th      = {hdr.toff, 2'b00};
		hdr_end = lh + COUNT_WIDTH'(hl);
		avail   = len - hdr_end;
		tl      = (hdr.total > 16'(hl)) ? COUNT_WIDTH'(hdr.total - 16'(hl)) : avail;
		pay     = tl;

		// Reject unsupported links, short frames and bad IP headers
		fail = (link_type == LINK_NONE) || (len < lh + COUNT_WIDTH'(IP_MIN_BYTES))
			|| (hdr.version != IP_VERSION4) || (hl < IP_MIN_BYTES) || (len < hdr_end);

		res.src = hdr.src;
		res.dst = hdr.dst;
		if (hdr.proto == PROTO_TCP) begin
			res.kind  = KIND_TCP;
			res.sport = hdr.sport;
			res.dport = hdr.dport;
			res.flags = hdr.flags;
			pay       = (tl > COUNT_WIDTH'(th)) ? tl - COUNT_WIDTH'(th) : '0;
			if (avail < COUNT_WIDTH'(TCP_MIN_BYTES)) begin
				fail = 1'b1;
			end
		end else if (hdr.proto == PROTO_UDP) begin
			res.kind  = KIND_UDP;
			res.sport = hdr.sport;
			res.dport = hdr.dport;
			pay       = (tl > COUNT_WIDTH'(UDP_HDR_BYTES)) ?
				tl - COUNT_WIDTH'(UDP_HDR_BYTES) : '0;
			if (avail < COUNT_WIDTH'(UDP_HDR_BYTES)) begin
				fail = 1'b1;
			end
		end else if (hdr.proto == PROTO_ICMP) begin
			res.kind = KIND_ICMP;
		end else begin
			res.kind = KIND_OTHER;
		end

		// Saturate the payload length
		res.pay = (pay > PAY_MAX_W) ? PAY_MAX : 16'(pay);
		res.ok  = 1'b1;

		// Drop every field of a failed frame
		if (fail) begin
			res = '0;
		end
	end

endmodule

[hdl/ipv4_transport_header_parser.sv]
// Top level of the IPv4 transport header parser.
// Depends on ith_pkg, ith_capture and ith_check.
//
// Accepts one frame byte per clock while in_ready is high, with a
// last-byte mark, and emits one result per frame: the last byte's capture
// is registered into a finish stage, and the checks and payload
// arithmetic between that stage and the output register form the
// longest path. Non-last bytes produce no result. With out_ready held high
// the block sustains one byte every cycle, frames back to back; a stalled
// result holds in the output register while one further finished frame
// waits in the finish stage. The link type register may be written at any
// time, but only takes meaningful effect between frames.
module ipv4_transport_header_parser import ith_pkg::*; #(
	parameter int COUNT_WIDTH = 17
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        parse_ok,
	output logic [1:0]  protocol_kind,
	output logic [31:0] src_address,
	output logic [31:0] dst_address,
	output logic [15:0] src_port,
	output logic [15:0] dst_port,
	output logic [7:0]  tcp_flags,
	output logic [15:0] payload_length
);

	link_t                  link_q;
	logic                   take;
	hdr_t                   hdr_next;
	logic [COUNT_WIDTH-1:0] len_next;

	logic                   fin_v_s1;
	hdr_t                   hdr_s1;
	logic [COUNT_WIDTH-1:0] len_s1;
	link_t                  link_s1;
	logic                   s1_adv;

	res_t                   res;
	res_t                   out_q;
	logic                   out_v_q;

	// Link type register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= LINK_ETH;
		end else if (cfg_valid) begin
			link_q <= link_t'(cfg_data);
		end
	end

	// Handshake: hold input while a finished frame cannot move on
	assign s1_adv   = fin_v_s1 && (!out_v_q || out_ready);
	assign in_ready = !fin_v_s1 || s1_adv;
	assign take     = in_valid && in_ready;

	ith_capture #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.link_type (link_q),
		.take      (take),
		.byte_value(byte_value),
		.last_byte (last_byte),
		.hdr_next  (hdr_next),
		.len_next  (len_next)
	);

	// Finish stage: snapshot the frame on its last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s1 <= 1'b0;
		end else if (take && last_byte) begin
			fin_v_s1 <= 1'b1;
		end else if (s1_adv) begin
			fin_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_byte) begin
			hdr_s1  <= hdr_next;
			len_s1  <= len_next;
			link_s1 <= link_q;
		end
	end

	ith_check #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_check (
		.link_type(link_s1),
		.hdr      (hdr_s1),
		.len      (len_s1),
		.res      (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_v_q;
	assign parse_ok       = out_q.ok;
	assign protocol_kind  = out_q.kind;
	assign src_address    = out_q.src;
	assign dst_address    = out_q.dst;
	assign src_port       = out_q.sport;
	assign dst_port       = out_q.dport;
	assign tcp_flags      = out_q.flags;
	assign payload_length = out_q.pay;

endmodule

[test/ipv4_transport_header_parser_tb.sv]
// Testbench for ipv4_transport_header_parser: streams captured frames under every link type,
// predicts each parse result in a scoreboard class and checks it field by field.
// Depends on ith_pkg and the parser RTL.
module ipv4_transport_header_parser_tb import ith_pkg::*;;

	localparam int COUNT_W = 17;
	localparam int unsigned IDLE_LIMIT = 4000;

	// Frame-level predictor and store of expected parse results
	class frame_scoreboard;
		link_t link_sel;
		logic [COUNT_W-1:0] offset;
		hdr_t captured;
		res_t expected_q[$];
		int unsigned errors;

		function new();
			link_sel = LINK_ETH;
			offset = '0;
			captured = '0;
			errors = 0;
		endfunction

		function void set_link(link_t l);
			link_sel = l;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Capture one accepted byte; on the last byte predict the result
		function void note_byte(logic [7:0] b, logic is_last);
			int unsigned lh, pos, p, hl, t, len, avail, tl, th, pay;
			logic lk;
			res_t r;
			lk = 1'b1;
			case (link_sel)
				LINK_ETH:  lh = 14;
				LINK_NULL: lh = 4;
				LINK_SLL:  lh = 16;
				default: begin
					lh = 0;
					lk = 1'b0;
				end
			endcase
			pos = 32'(offset);
			if (lk && pos >= lh) begin
				p = pos - lh;
				if (p == 0) begin
					captured.version = b[7:4];
					captured.words = b[3:0];
				end else if (p == 2 || p == 3) begin
					captured.total = {captured.total[7:0], b};
				end else if (p == 9) begin
					captured.proto = b;
				end else if (p >= 12 && p < 16) begin
					captured.src = {captured.src[23:0], b};
				end else if (p >= 16 && p < 20) begin
					captured.dst = {captured.dst[23:0], b};
				end
				hl = captured.words * 4;
				if (captured.words >= IHL_MIN && p >= hl) begin
					t = p - hl;
					if (t == 0 || t == 1)
						captured.sport = {captured.sport[7:0], b};
					else if (t == 2 || t == 3)
						captured.dport = {captured.dport[7:0], b};
					else if (t == 12)
						captured.toff = b[7:4];
					else if (t == 13)
						captured.flags = b;
				end
			end
			// hold the count at its top value on very long frames
			if (offset != '1)
				offset = offset + 1'b1;
			if (!is_last)
				return;

			r = '0;
			len = 32'(offset);
			hl = captured.words * 4;
			if (lk && len >= lh + IP_MIN_BYTES && captured.version == IP_VERSION4 &&
					hl >= IP_MIN_BYTES && len >= lh + hl) begin
				avail = len - lh - hl;
				tl = (captured.total > hl) ? captured.total - hl : avail;
				r.ok = 1'b1;
				r.src = captured.src;
				r.dst = captured.dst;
				case (captured.proto)
					PROTO_TCP: begin
						r.kind = KIND_TCP;
						r.sport = captured.sport;
						r.dport = captured.dport;
						r.flags = captured.flags;
						th = captured.toff * 4;
						pay = (tl > th) ? tl - th : 0;
						if (avail < TCP_MIN_BYTES)
							r.ok = 1'b0;
					end
					PROTO_UDP: begin
						r.kind = KIND_UDP;
						r.sport = captured.sport;
						r.dport = captured.dport;
						pay = (tl > UDP_HDR_BYTES) ? tl - UDP_HDR_BYTES : 0;
						if (avail < UDP_HDR_BYTES)
							r.ok = 1'b0;
					end
					PROTO_ICMP: begin
						r.kind = KIND_ICMP;
						pay = tl;
					end
					default: begin
						r.kind = KIND_OTHER;
						pay = tl;
					end
				endcase
				r.pay = (pay > PAY_MAX) ? PAY_MAX : pay[15:0];
				// a failed parse reports all zeros
				if (!r.ok)
					r = '0;
			end
			expected_q.push_back(r);
			offset = '0;
			captured = '0;
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task compare(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		// Match one accepted result against the oldest prediction
		task check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				report("result with no frame pending");
			end else begin
				want = expected_q.pop_front();
				compare("parse_ok", 32'(got.ok), 32'(want.ok));
				compare("protocol_kind", 32'(got.kind), 32'(want.kind));
				compare("src_address", got.src, want.src);
				compare("dst_address", got.dst, want.dst);
				compare("src_port", 32'(got.sport), 32'(want.sport));
				compare("dst_port", 32'(got.dport), 32'(want.dport));
				compare("tcp_flags", 32'(got.flags), 32'(want.flags));
				compare("payload_length", 32'(got.pay), 32'(want.pay));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte_value;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        parse_ok;
	logic [1:0]  protocol_kind;
	logic [31:0] src_address;
	logic [31:0] dst_address;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [7:0]  tcp_flags;
	logic [15:0] payload_length;

	frame_scoreboard sb = new();
	res_t seen;
	logic [7:0] frame_bytes[$];
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned bytes_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned quiet_cycles = 0;

	ipv4_transport_header_parser #(
		.COUNT_WIDTH(COUNT_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_value(byte_value),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.parse_ok(parse_ok),
		.protocol_kind(protocol_kind),
		.src_address(src_address),
		.dst_address(dst_address),
		.src_port(src_port),
		.dst_port(dst_port),
		.tcp_flags(tcp_flags),
		.payload_length(payload_length)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the result side at the current rate
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Sample handshakes, feed the scoreboard and watch for a hang
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			seen.ok = parse_ok;
			seen.kind = kind_t'(protocol_kind);
			seen.src = src_address;
			seen.dst = dst_address;
			seen.sport = src_port;
			seen.dport = dst_port;
			seen.flags = tcp_flags;
			seen.pay = payload_length;
			sb.check_result(seen);
		end
		if (cfg_valid && cfg_ready)
			sb.set_link(link_t'(cfg_data));
		if (in_valid && in_ready)
			sb.note_byte(byte_value, last_byte);
		if ((out_valid && out_ready) || (cfg_valid && cfg_ready) || (in_valid && in_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no request accepted for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offer one byte request, idling first at the sender rate
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		last_byte <= is_last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		int unsigned i;
		for (i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		frames_sent++;
	endtask

	// Pause the sender until every predicted result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic write_link(input link_t link);
		cfg_valid <= 1'b1;
		cfg_data <= link;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Build a frame: link header, IPv4 header with options, transport bytes
	task automatic make_frame(input int unsigned lh, input logic [3:0] ver,
			input logic [3:0] ihl, input logic [7:0] proto, input logic [3:0] toff,
			input logic [15:0] total, input int unsigned tail);
		int unsigned i, opts;
		logic [7:0] v;
		frame_bytes.delete();
		opts = (ihl > IHL_MIN) ? ihl * 4 - IP_MIN_BYTES : 0;
		for (i = 0; i < lh; i++)
			frame_bytes.push_back(8'($urandom_range(255)));
		frame_bytes.push_back({ver, ihl});
		frame_bytes.push_back(8'($urandom_range(255)));
		frame_bytes.push_back(total[15:8]);
		frame_bytes.push_back(total[7:0]);
		for (i = 0; i < 5; i++)
			frame_bytes.push_back(8'($urandom_range(255)));
		frame_bytes.push_back(proto);
		for (i = 0; i < 10 + opts; i++)
			frame_bytes.push_back(8'($urandom_range(255)));
		for (i = 0; i < tail; i++) begin
			v = 8'($urandom_range(255));
			if (i == 12 && proto == PROTO_TCP)
				v[7:4] = toff;
			frame_bytes.push_back(v);
		end
	endtask

	// Mostly well-formed frames with random content, some broken or cut short
	task automatic rand_frame(input link_t link);
		int unsigned lh, ip_bytes, tail, pick, cut;
		logic [3:0] ver, ihl, toff;
		logic [7:0] proto;
		logic [15:0] total;
		lh = (link == LINK_NONE) ? $urandom_range(16) : link_len(link);
		ver = IP_VERSION4;
		if ($urandom_range(15) == 0)
			ver = 4'($urandom_range(15));
		pick = $urandom_range(19);
		if (pick == 0)
			ihl = 4'($urandom_range(4));
		else if (pick < 4)
			ihl = 4'($urandom_range(15, 6));
		else
			ihl = IHL_MIN;
		pick = $urandom_range(9);
		if (pick < 4)
			proto = PROTO_TCP;
		else if (pick < 7)
			proto = PROTO_UDP;
		else if (pick < 8)
			proto = PROTO_ICMP;
		else
			proto = 8'($urandom_range(255));
		toff = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 5));
		if (proto == PROTO_TCP)
			tail = ((toff * 4 > TCP_MIN_BYTES) ? toff * 4 : TCP_MIN_BYTES) + $urandom_range(32);
		else if (proto == PROTO_UDP)
			tail = UDP_HDR_BYTES + $urandom_range(32);
		else
			tail = $urandom_range(32);
		// short transport section
		if ($urandom_range(9) == 0)
			tail = $urandom_range(tail);
		ip_bytes = (ihl > IHL_MIN) ? ihl * 4 : IP_MIN_BYTES;
		pick = $urandom_range(9);
		if (pick < 8)
			total = 16'(ip_bytes + tail);
		else if (pick == 8)
			total = 16'd0;
		else
			total = 16'($urandom_range(65535));
		make_frame(lh, ver, ihl, proto, toff, total, tail);
		// truncated capture
		if ($urandom_range(19) == 0) begin
			cut = $urandom_range(frame_bytes.size(), 1);
			while (frame_bytes.size() > cut)
				frame_bytes.pop_back();
		end
		send_frame();
	endtask

	task automatic directed_frames();
		// one-byte frame and a frame cut inside the addresses
		frame_bytes.delete();
		frame_bytes.push_back(8'hFF);
		send_frame();
		make_frame(NULL_HDR_BYTES, IP_VERSION4, IHL_MIN, PROTO_TCP, 4'd5, 16'd40, 20);
		while (frame_bytes.size() > 20)
			frame_bytes.pop_back();
		send_frame();
		// each protocol class, well formed
		make_frame(NULL_HDR_BYTES, IP_VERSION4, IHL_MIN, PROTO_TCP, 4'd5, 16'd40, 20);
		send_frame();
		make_frame(NULL_HDR_BYTES, IP_VERSION4, IHL_MIN, PROTO_UDP, 4'd0, 16'd32, 12);
		send_frame();
		make_frame(NULL_HDR_BYTES, IP_VERSION4, IHL_MIN, PROTO_ICMP, 4'd0, 16'd28, 8);
		send_frame();
		make_frame(NULL_HDR_BYTES, IP_VERSION4, IHL_MIN, 8'hFF, 4'd0, 16'd20, 0);
		send_frame();
		// header length below minimum, bad version
		make_frame(NULL_HDR_BYTES, IP_VERSION4, 4'd4, PROTO_TCP, 4'd5, 16'd40, 0);
		send_frame();
		make_frame(NULL_HDR_BYTES, IP_VERSION4, 4'd0, PROTO_UDP, 4'd0, 16'd28, 0);
		send_frame();
		make_frame(NULL_HDR_BYTES, 4'd6, IHL_MIN, PROTO_TCP, 4'd5, 16'd40, 0);
		send_frame();
		// full options and largest data offset
		make_frame(NULL_HDR_BYTES, IP_VERSION4, 4'd15, PROTO_TCP, 4'd15, 16'd80, 20);
		send_frame();
		// transport header too short for its protocol
		make_frame(NULL_HDR_BYTES, IP_VERSION4, IHL_MIN, PROTO_TCP, 4'd5, 16'd30, 10);
		send_frame();
		make_frame(NULL_HDR_BYTES, IP_VERSION4, IHL_MIN, PROTO_UDP, 4'd0, 16'd24, 4);
		send_frame();
		// total length zero and at its maximum
		make_frame(NULL_HDR_BYTES, IP_VERSION4, IHL_MIN, PROTO_UDP, 4'd0, 16'd0, 12);
		send_frame();
		make_frame(NULL_HDR_BYTES, IP_VERSION4, IHL_MIN, PROTO_TCP, 4'd5, 16'hFFFF, 20);
		send_frame();
		// data offset beyond transport length floors payload
		make_frame(NULL_HDR_BYTES, IP_VERSION4, IHL_MIN, PROTO_TCP, 4'd15, 16'd40, 20);
		send_frame();
	endtask

	task automatic run_phase(input link_t link, input int unsigned idle,
			input int unsigned stall);
		int unsigned start_bytes, start_frames;
		drain_results();
		repeat (4) @(negedge clk);
		write_link(link);
		idle_pct = idle;
		stall_pct = stall;
		start_bytes = bytes_sent;
		start_frames = frames_sent;
		while (bytes_sent - start_bytes < 80 || frames_sent - start_frames < 2) begin
			rand_frame(link);
			if ($urandom_range(7) == 0)
				drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = LINK_ETH;
		in_valid = 1'b0;
		byte_value = 8'h00;
		last_byte = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_link(LINK_NULL);
		directed_frames();
		run_phase(LINK_NULL, 0, 0);
		run_phase(LINK_SLL, 69, 0);
		run_phase(LINK_ETH, 0, 69);
		run_phase(LINK_NULL, 15, 15);
		run_phase(LINK_NONE, 15, 15);
		drain_results();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
hdl/ith_pkg.sv
hdl/ith_capture.sv
hdl/ith_check.sv
hdl/ipv4_transport_header_parser.sv
test/ipv4_transport_header_parser_tb.sv
